// ===== sv/adaptive_vad_threshold_tracker_assert.svh =====
// Assertion macros for the VAD threshold tracker.
// Needs clk and rst in scope where used.
`ifndef ADAPTIVE_VAD_THRESHOLD_TRACKER_ASSERT_SVH
`define ADAPTIVE_VAD_THRESHOLD_TRACKER_ASSERT_SVH

// property that must hold at every edge out of reset
`define AVT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define AVT_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/avt_pkg.sv =====
// Shared types and constants for the VAD threshold tracker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package avt_pkg;

  localparam int ENERGY_W = 31;
  localparam int THR_W    = 16;
  localparam int DIV_W    = 50;
  localparam int QUO_W    = 31;
  localparam int STEP_W   = 5;
  localparam int OUT_W    = 56;

  localparam logic [THR_W-1:0]    INIT_THR_RESET = 16'd39322;
  localparam logic [ENERGY_W-1:0] FLOOR_RESET    = 31'd107374;
  localparam logic [THR_W-1:0]    MIN_THR_RESET  = 16'd19661;
  localparam logic [THR_W-1:0]    MAX_THR_RESET  = 16'd52429;
  localparam logic [THR_W-1:0]    RATE_RESET     = 16'd6554;

  localparam logic [31:0] EPS_Q30  = 32'd107374;
  localparam logic [16:0] HALF_Q16 = 17'd32768;
  localparam logic [16:0] ONE_Q16  = 17'd65536;

  localparam logic [STEP_W-1:0] ENERGY_STEPS = 5'd31;
  localparam logic [STEP_W-1:0] TARGET_STEPS = 5'd15;

  // register indexes
  localparam logic [2:0] REG_INIT_THR = 3'd0;
  localparam logic [2:0] REG_FLOOR    = 3'd1;
  localparam logic [2:0] REG_MIN_THR  = 3'd2;
  localparam logic [2:0] REG_MAX_THR  = 3'd3;
  localparam logic [2:0] REG_RATE     = 3'd4;

  typedef struct packed {
    logic shift;
    logic load;
    logic rotate;
    logic cmp;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/avt_cell.sv =====
// One history cell: holds an energy entry and a circulating rank token.
// Depends on avt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module avt_cell import avt_pkg::*; #(
  parameter int IDX_W    = 6,
  parameter int CELL_IDX = 0
) (
  input  wire  logic                clk,
  input  wire  cell_ctrl_t          ctrl,
  input  wire  logic                occupied,
  input  wire  logic [ENERGY_W-1:0] hist_in,
  output logic       [ENERGY_W-1:0] hist,
  input  wire  logic [ENERGY_W-1:0] tok_v_in,
  input  wire  logic [IDX_W-1:0]    tok_idx_in,
  input  wire  logic [IDX_W-1:0]    tok_rank_in,
  input  wire  logic                tok_ok_in,
  output logic       [ENERGY_W-1:0] tok_v,
  output logic       [IDX_W-1:0]    tok_idx,
  output logic       [IDX_W-1:0]    tok_rank,
  output logic                      tok_ok
);

  logic beats;

  // count this entry if it sorts ahead of the incoming token
  assign beats = ctrl.cmp && occupied &&
                 ((hist < tok_v_in) ||
                  ((hist == tok_v_in) && (IDX_W'(CELL_IDX) < tok_idx_in)));

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      hist <= hist_in;
    end
    if (ctrl.load) begin
      tok_v    <= hist;
      tok_idx  <= IDX_W'(CELL_IDX);
      tok_rank <= '0;
      tok_ok   <= occupied;
    end else if (ctrl.rotate) begin
      tok_v    <= tok_v_in;
      tok_idx  <= tok_idx_in;
      tok_rank <= tok_rank_in + IDX_W'(beats);
      tok_ok   <= tok_ok_in;
    end
  end

endmodule

`default_nettype wire

// ===== sv/avt_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// Depends on avt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module avt_div import avt_pkg::*; (
  input  wire  logic              clk,
  input  wire  logic              rst,
  input  wire  logic              start,
  input  wire  logic [DIV_W-1:0]  dividend,
  input  wire  logic [DIV_W-1:0]  divisor_top,
  input  wire  logic [STEP_W-1:0] steps,
  output logic                    done,
  output logic       [QUO_W-1:0]  quotient
);

  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dvs;
  logic [STEP_W-1:0] left;
  logic              busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (left == STEP_W'(1));
      if (start) begin
        rem      <= dividend;
        dvs      <= divisor_top;
        quotient <= '0;
        left     <= steps;
        busy     <= 1'b1;
      end else if (busy) begin
        if (rem >= dvs) begin
          rem      <= rem - dvs;
          quotient <= {quotient[QUO_W-2:0], 1'b1};
        end else begin
          quotient <= {quotient[QUO_W-2:0], 1'b0};
        end
        dvs  <= dvs >> 1;
        left <= left - 1'b1;
        if (left == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/adaptive_vad_threshold_tracker.sv =====
// Adaptive VAD threshold tracker: top level, config port, sequencer.
// Depends on avt_pkg, avt_cell, avt_div and the assertion macro header.
//
// Samples enter on the s_ stream, one per cycle, tlast on the final sample
// of a buffer. Each buffer gives one result transaction on the m_ stream:
// mean energy, tracked threshold and three flags.
// Throughput: one sample per cycle inside a buffer. After the last sample
// the block stops taking samples while it finishes the buffer: the
// 31-step energy divide when the threshold does not adapt, and when it
// adapts also two passes of rank tokens around the ring of history cells
// plus the 15-step target divide.
// The result is presented once the buffer is finished, provided the
// previous result was taken.
// A finished result sits in an output register; the next buffer's samples
// are taken while it waits, and the block only holds before loading a new
// result while the previous one is not yet taken.
// Reset (rst, synchronous) clears counters and history fill and loads the
// register reset values; history contents need no clearing.
// The user must write registers over the APB port only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
`include "adaptive_vad_threshold_tracker_assert.svh"

module adaptive_vad_threshold_tracker import avt_pkg::*; #(
  parameter int HISTORY_DEPTH      = 50,
  parameter int MIN_FILL           = 10,
  parameter int MAX_BUFFER_SAMPLES = 65535,
  parameter int SAMPLE_BITS        = 16
) (
  input  wire  logic                                clk,
  input  wire  logic                                rst,
  input  wire  logic                                s_tvalid,
  output logic                                      s_tready,
  // sample (SAMPLE_BITS), zero padded to bytes
  input  wire  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
  input  wire  logic                                s_tlast,
  output logic                                      m_tvalid,
  input  wire  logic                                m_tready,
  // mean_energy[30:0], threshold_now[46:31], energy_kept[47],
  // threshold_adapted[48], count_overflow[49], zeros above
  output logic       [OUT_W-1:0]                    m_tdata,
  input  wire  logic                                psel,
  input  wire  logic                                penable,
  input  wire  logic                                pwrite,
  input  wire  logic [4:0]                          paddr,
  input  wire  logic [31:0]                         pwdata,
  output logic       [31:0]                         prdata,
  output logic                                      pready
);

  localparam int CNT_W  = $clog2(MAX_BUFFER_SAMPLES + 1);
  localparam int SUM_W  = CNT_W + ENERGY_W;
  localparam int IDX_W  = $clog2(HISTORY_DEPTH);
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int RCNT_W = $clog2(2 * HISTORY_DEPTH + 1);
  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int SH_R   = (SAMPLE_BITS >= 16) ? 2 * (SAMPLE_BITS - 16) : 0;
  localparam int SH_L   = (SAMPLE_BITS < 16) ? 2 * (16 - SAMPLE_BITS) : 0;

  typedef enum logic [3:0] {
    ST_ACC, ST_ESTART, ST_EWAIT, ST_DECIDE, ST_RANK, ST_TPREP, ST_TSTART,
    ST_TWAIT, ST_EMA1, ST_EMA2, ST_CLAMP, ST_OUT
  } state_t;

  state_t state;

  // configuration
  logic [THR_W-1:0]    init_thr, min_thr, max_thr, rate;
  logic [ENERGY_W-1:0] floor_e;
  logic                cfg_wr;

  // accumulation
  logic                     s_acc, last_taken;
  logic signed [SAMPLE_BITS-1:0] smp;
  logic [SAMPLE_BITS-1:0]   mag;
  logic [SQ_W-1:0]          sq_full;
  logic [ENERGY_W-1:0]      sq_norm, sq;
  logic                     sq_vld, sq_last;
  logic [SUM_W-1:0]         sum;
  logic [CNT_W-1:0]         count;
  logic                     ovf;

  // end of buffer
  logic [ENERGY_W-1:0] energy;
  logic                kept, adapted;
  logic [FILL_W-1:0]   fill, fill_inc;
  logic [RCNT_W-1:0]   rcnt;
  logic [IDX_W-1:0]    r1, r2, r3;
  logic [FILL_W+1:0]   fill3;
  logic [ENERGY_W-1:0] q1, med, q3;
  logic [32:0]         d3;
  logic [34:0]         den5;
  logic [31:0]         spread;
  logic [THR_W-1:0]    thr, target;
  logic [32:0]         p1;
  logic [31:0]         p2;
  logic [33:0]         ema_sum;
  logic [17:0]         ema_raw;
  logic [THR_W-1:0]    ema, t_hi, t_clamp;

  // output register
  logic [ENERGY_W-1:0] out_energy;
  logic [THR_W-1:0]    out_thr;
  logic                out_kept, out_adapted, out_ovf;
  logic                out_load;

  // divider
  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_dividend, div_divisor;
  logic [STEP_W-1:0] div_steps;
  logic [QUO_W-1:0]  div_q;

  // cell ring
  cell_ctrl_t          ctrl;
  logic [HISTORY_DEPTH-1:0] occ;
  logic [ENERGY_W-1:0] hist_a   [HISTORY_DEPTH];
  logic [ENERGY_W-1:0] tok_v_a  [HISTORY_DEPTH];
  logic [IDX_W-1:0]    tok_idx_a[HISTORY_DEPTH];
  logic [IDX_W-1:0]    tok_rk_a [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] tok_ok_a;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[4:2])
      REG_INIT_THR: prdata = 32'(init_thr);
      REG_FLOOR:    prdata = 32'(floor_e);
      REG_MIN_THR:  prdata = 32'(min_thr);
      REG_MAX_THR:  prdata = 32'(max_thr);
      REG_RATE:     prdata = 32'(rate);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_thr <= INIT_THR_RESET;
      floor_e  <= FLOOR_RESET;
      min_thr  <= MIN_THR_RESET;
      max_thr  <= MAX_THR_RESET;
      rate     <= RATE_RESET;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_INIT_THR: init_thr <= pwdata[THR_W-1:0];
        REG_FLOOR:    floor_e  <= pwdata[ENERGY_W-1:0];
        REG_MIN_THR:  min_thr  <= pwdata[THR_W-1:0];
        REG_MAX_THR:  max_thr  <= pwdata[THR_W-1:0];
        REG_RATE:     rate     <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- sample squaring ----------------
  assign s_tready = (state == ST_ACC) && !last_taken;
  assign s_acc    = s_tvalid && s_tready;
  assign smp      = signed'(s_tdata[SAMPLE_BITS-1:0]);
  assign mag      = smp[SAMPLE_BITS-1] ? SAMPLE_BITS'(-smp) : SAMPLE_BITS'(smp);
  assign sq_full  = SQ_W'(mag) * SQ_W'(mag);

  always_comb begin
    if (SAMPLE_BITS >= 16) begin
      sq_norm = ENERGY_W'(sq_full >> SH_R);
    end else begin
      sq_norm = ENERGY_W'(ENERGY_W'(sq_full) << SH_L);
    end
  end

  always_ff @(posedge clk) begin
    sq      <= sq_norm;
    sq_last <= s_tlast;
  end

  // ---------------- cell ring ----------------
  assign ctrl.shift  = (state == ST_DECIDE) && (energy > floor_e);
  assign ctrl.load   = (state == ST_RANK) && (rcnt == '0);
  assign ctrl.rotate = (state == ST_RANK) && (rcnt != '0);
  assign ctrl.cmp    = (state == ST_RANK) && (rcnt != '0) &&
                       (rcnt <= RCNT_W'(HISTORY_DEPTH));

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    localparam int PREV = (i == 0) ? HISTORY_DEPTH - 1 : i - 1;
    assign occ[i] = FILL_W'(i) < fill;
    avt_cell #(.IDX_W(IDX_W), .CELL_IDX(i)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occ[i]),
      .hist_in    ((i == 0) ? energy : hist_a[PREV]),
      .hist       (hist_a[i]),
      .tok_v_in   (tok_v_a[PREV]),
      .tok_idx_in (tok_idx_a[PREV]),
      .tok_rank_in(tok_rk_a[PREV]),
      .tok_ok_in  (tok_ok_a[PREV]),
      .tok_v      (tok_v_a[i]),
      .tok_idx    (tok_idx_a[i]),
      .tok_rank   (tok_rk_a[i]),
      .tok_ok     (tok_ok_a[i])
    );
  end

  assign fill3 = (FILL_W+2)'(fill) + ((FILL_W+2)'(fill) << 1);
  assign r1    = IDX_W'(fill >> 2);
  assign r2    = IDX_W'(fill >> 1);
  assign r3    = IDX_W'(fill3 >> 2);
  assign fill_inc = (fill == FILL_W'(HISTORY_DEPTH)) ? fill : fill + 1'b1;

  // ---------------- divider ----------------
  assign div_start = (state == ST_ESTART) || (state == ST_TSTART);
  assign div_steps = (state == ST_ESTART) ? ENERGY_STEPS : TARGET_STEPS;

  always_comb begin
    if (state == ST_ESTART) begin
      div_dividend = DIV_W'(sum);
      div_divisor  = DIV_W'(count) << 30;
    end else begin
      div_dividend = (DIV_W'(d3) << 16) + DIV_W'(den5);
      div_divisor  = DIV_W'(den5) << 15;
    end
  end

  avt_div u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .dividend   (div_dividend),
    .divisor_top(div_divisor),
    .steps      (div_steps),
    .done       (div_done),
    .quotient   (div_q)
  );

  // ---------------- threshold arithmetic ----------------
  assign spread  = 32'(q3) - 32'(q1) + EPS_Q30;
  assign ema_sum = 34'(p1) + 34'(p2) + 34'(HALF_Q16);
  assign ema_raw = 18'(ema_sum >> 16);
  assign ema     = (ema_raw > 18'(16'hFFFF)) ? 16'hFFFF : THR_W'(ema_raw);
  assign t_hi    = (ema < max_thr) ? ema : max_thr;
  assign t_clamp = (t_hi > min_thr) ? t_hi : min_thr;

  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_ACC;
      last_taken <= 1'b0;
      sq_vld     <= 1'b0;
      sum        <= '0;
      count      <= '0;
      ovf        <= 1'b0;
      fill       <= '0;
      rcnt       <= '0;
      thr        <= INIT_THR_RESET;
      m_tvalid   <= 1'b0;
    end else begin
      sq_vld <= s_acc;
      if (s_acc && s_tlast) begin
        last_taken <= 1'b1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_wr && (paddr[4:2] == REG_INIT_THR)) begin
        thr <= pwdata[THR_W-1:0];
      end

      case (state)
        ST_ACC: begin
          if (sq_vld) begin
            if (count < CNT_W'(MAX_BUFFER_SAMPLES)) begin
              sum   <= sum + SUM_W'(sq);
              count <= count + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
            if (sq_last) begin
              state <= ST_ESTART;
            end
          end
        end
        ST_ESTART: state <= ST_EWAIT;
        ST_EWAIT: begin
          if (div_done) begin
            energy <= (count == '0) ? '0 : div_q;
            state  <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          kept    <= energy > floor_e;
          adapted <= (energy > floor_e) && (fill_inc >= FILL_W'(MIN_FILL));
          if (energy > floor_e) begin
            fill <= fill_inc;
            if (fill_inc >= FILL_W'(MIN_FILL)) begin
              rcnt    <= '0;
              state   <= ST_RANK;
            end else begin
              state <= ST_OUT;
            end
          end else begin
            state <= ST_OUT;
          end
        end
        ST_RANK: begin
          // second pass: pick the order statistics as tokens cross cell 0
          if (rcnt > RCNT_W'(HISTORY_DEPTH) && tok_ok_a[0]) begin
            if (tok_rk_a[0] == r1) q1  <= tok_v_a[0];
            if (tok_rk_a[0] == r2) med <= tok_v_a[0];
            if (tok_rk_a[0] == r3) q3  <= tok_v_a[0];
          end
          rcnt <= rcnt + 1'b1;
          if (rcnt == RCNT_W'(2 * HISTORY_DEPTH)) begin
            state <= ST_TPREP;
          end
        end
        ST_TPREP: begin
          d3    <= (33'(med - q1) << 1) + 33'(med - q1);
          den5  <= (35'(spread) << 2) + 35'(spread);
          state <= ST_TSTART;
        end
        ST_TSTART: state <= ST_TWAIT;
        ST_TWAIT: begin
          if (div_done) begin
            target <= THR_W'(HALF_Q16 + 17'(div_q[14:0]));
            state  <= ST_EMA1;
          end
        end
        ST_EMA1: begin
          p1    <= 33'(thr) * 33'(ONE_Q16 - 17'(rate));
          state <= ST_EMA2;
        end
        ST_EMA2: begin
          p2    <= 32'(target) * 32'(rate);
          state <= ST_CLAMP;
        end
        ST_CLAMP: begin
          thr   <= t_clamp;
          state <= ST_OUT;
        end
        ST_OUT: begin
          // hold until the previous result is taken
          if (out_load) begin
            out_energy  <= energy;
            out_thr     <= thr;
            out_kept    <= kept;
            out_adapted <= adapted;
            out_ovf     <= ovf;
            sum         <= '0;
            count       <= '0;
            ovf         <= 1'b0;
            last_taken  <= 1'b0;
            state       <= ST_ACC;
          end
        end
        default: state <= ST_ACC;
      endcase
    end
  end

  assign m_tdata = {6'b0, out_ovf, out_adapted, out_kept, out_thr, out_energy};

  `AVT_ASSERT_ALWAYS(a_fill_bound, fill <= FILL_W'(HISTORY_DEPTH), "history fill beyond depth")
  `AVT_ASSERT_IMPLY(a_adapt_kept, m_tvalid && out_adapted, out_kept, "adapted without keep")
  `AVT_ASSERT_IMPLY(a_clamp_low, m_tvalid && out_adapted, out_thr >= min_thr, "threshold below min")
  `AVT_ASSERT_NEXT(a_no_take_busy, state == ST_RANK, !s_tready, "sample taken while ranking")

endmodule

`default_nettype wire

// ===== verif/avt_scoreboard.sv =====
// Result checker for the VAD threshold tracker: watches the sample and result
// streams and the APB writes, predicts each buffer result and compares it.
// Depends on avt_pkg.
`timescale 1ns / 1ps

module avt_scoreboard import avt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);
  localparam int DEPTH = 50;
  localparam int FILL_MIN = 10;
  localparam int MAX_SAMPLES = 65535;

  // last member sits in the lowest bits, matching the tdata layout
  typedef struct packed {
    logic        ovf;
    logic        adapted;
    logic        kept;
    logic [15:0] thr;
    logic [30:0] energy;
  } buf_result_t;

  logic [15:0] init_thr, min_thr, max_thr, rate;
  logic [30:0] floor_q30;
  logic [46:0] sq_sum;
  int unsigned n_samples;
  logic        ovf_seen;
  logic [30:0] hist [DEPTH];
  int unsigned fill, oldest;
  logic [15:0] thr;
  buf_result_t expected_results[$];

  function automatic logic [15:0] next_threshold();
    logic [30:0] srt [DEPTH];
    logic [30:0] v;
    int j;
    logic [63:0] q1, med, q3, num, den, tgt, ema;
    for (int i = 0; i < fill; i++) srt[i] = hist[i];
    for (int i = 1; i < fill; i++) begin
      v = srt[i];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    q1 = srt[fill/4];
    med = srt[fill/2];
    q3 = srt[(3*fill)/4];
    num = (med - q1) * 64'd98304;
    den = 64'd5 * (q3 - q1 + 64'd107374);
    tgt = 64'd32768 + (2*num + den) / (2*den);
    ema = (64'(thr) * (64'd65536 - rate) + tgt * rate + 64'd32768) >> 16;
    if (ema > 65535) ema = 65535;
    if (ema > max_thr) ema = max_thr;
    if (ema < min_thr) ema = min_thr;
    return ema[15:0];
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    logic [15:0]  mag;
    logic [63:0]  e;
    buf_result_t  r, got;
    if (rst) begin
      init_thr <= INIT_THR_RESET; floor_q30 <= FLOOR_RESET;
      min_thr <= MIN_THR_RESET; max_thr <= MAX_THR_RESET; rate <= RATE_RESET;
      thr = INIT_THR_RESET;
      sq_sum = '0; n_samples = 0; ovf_seen = 0; fill = 0; oldest = 0;
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_INIT_THR: begin init_thr <= pwdata[15:0]; thr = pwdata[15:0]; end
          REG_FLOOR:    floor_q30 <= pwdata[30:0];
          REG_MIN_THR:  min_thr <= pwdata[15:0];
          REG_MAX_THR:  max_thr <= pwdata[15:0];
          REG_RATE:     rate <= pwdata[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        // blocking copies so a buffer end sees this sample
        mag = s_tdata[15] ? 16'(-s_tdata) : s_tdata;
        if (s_tdata == 16'h8000) e = 64'd1 << 30;
        else e = 64'(mag) * mag;
        if (n_samples < MAX_SAMPLES) begin
          sq_sum = sq_sum + e[46:0];
          n_samples = n_samples + 1;
        end else ovf_seen = 1;
        if (s_tlast) begin
          e = n_samples ? sq_sum / n_samples : 0;
          r = '0;
          r.energy = e[30:0];
          if (r.energy > floor_q30) begin
            r.kept = 1;
            if (fill < DEPTH) begin
              hist[(oldest + fill) % DEPTH] = r.energy;
              fill = fill + 1;
            end else begin
              hist[oldest] = r.energy;
              oldest = (oldest + 1) % DEPTH;
            end
            if (fill >= FILL_MIN) begin
              thr = next_threshold();
              r.adapted = 1;
            end
          end
          r.thr = thr;
          r.ovf = ovf_seen;
          expected_results = {expected_results, r};
          sq_sum = 0; n_samples = 0; ovf_seen = 0;
        end
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[49:0];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          r = expected_results.pop_front();
          if (got !== r) begin
            $display("%0t: result expected energy=%0d thr=%0d kept=%b adapted=%b ovf=%b",
                     $time, r.energy, r.thr, r.kept, r.adapted, r.ovf);
            $display("%0t: result actual   energy=%0d thr=%0d kept=%b adapted=%b ovf=%b",
                     $time, got.energy, got.thr, got.kept, got.adapted, got.ovf);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== verif/tb_adaptive_vad_threshold_tracker.sv =====
// Stimulus top for the VAD threshold tracker: drives samples, results ready
// and APB writes, gives the verdict. Depends on avt_pkg and avt_scoreboard.
`timescale 1ns / 1ps

module tb_adaptive_vad_threshold_tracker;
  import avt_pkg::*;

  // an index past the register list
  localparam logic [2:0] REG_UNUSED = 3'd5;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready, s_tlast = 0;
  logic [15:0] s_tdata = '0;
  logic m_tvalid, m_tready = 0;
  logic [55:0] m_tdata;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  int fail_count, pending;
  bit quiet_ready = 0, hold_ready = 0;
  longint cycles = 0;

  always #2 clk = ~clk;

  adaptive_vad_threshold_tracker i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  avt_scoreboard i_scoreboard (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending
  );

  // receiver: random stall bursts, a long hold on request, none when quiet
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_ready) begin
        m_tready <= 0;
        repeat (400) @(negedge clk);
        hold_ready = 0;
      end else if (!quiet_ready && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 12);
        m_tready <= 0;
        repeat (n - 1) @(negedge clk);
      end else m_tready <= 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // leaves tvalid high; the next sample, a gap or drain() takes it over
  task automatic send_sample(input logic [15:0] smp, input logic last, input bit gaps);
    if (gaps && $urandom_range(0, 9) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    s_tvalid <= 1; s_tdata <= smp; s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // a buffer of len samples with loudness scale shaping its energy
  task automatic send_buffer(input int len, input int scale, input bit gaps);
    logic [15:0] v;
    for (int i = 0; i < len; i++) begin
      v = 16'($signed($urandom_range(0, 2 * scale)) - scale);
      send_sample(v, i == len - 1, gaps);
    end
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    // every buffer, kept or not, is already counted in pending; this is an idle gap
    repeat (200) @(negedge clk);
  endtask

  initial begin
    int scale;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: extremes, single-sample and two-sample buffers
    send_sample(16'h8000, 1, 0);
    send_sample(16'h7fff, 1, 0);
    send_sample(16'h0000, 1, 0);
    send_sample(16'hffff, 0, 0);
    send_sample(16'h0001, 1, 0);
    send_sample(16'h5555, 0, 0);
    send_sample(16'haaaa, 1, 0);
    for (int i = 0; i < 14; i++) send_buffer(1, 32767, 0);
    drain();
    // register sweep with extremes, random values and reset values, including crossed clamps
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin reg_write(REG_INIT_THR, 0); reg_write(REG_FLOOR, 32'h4000_0000);
                 reg_write(REG_MIN_THR, 0); reg_write(REG_MAX_THR, 16'hffff);
                 reg_write(REG_RATE, 16'hffff); end
        1: begin reg_write(REG_INIT_THR, 16'hffff); reg_write(REG_FLOOR, 0);
                 reg_write(REG_MIN_THR, 40000); reg_write(REG_MAX_THR, 20000);
                 reg_write(REG_RATE, 0); end
        2: begin reg_write(REG_INIT_THR, $urandom); reg_write(REG_FLOOR, $urandom_range(0, 5000000));
                 reg_write(REG_MIN_THR, $urandom_range(0, 30000));
                 reg_write(REG_MAX_THR, $urandom_range(30000, 65535));
                 reg_write(REG_RATE, $urandom); end
        3: begin reg_write(REG_FLOOR, 32'h7fff_ffff); reg_write(REG_RATE, 32768);
                 reg_write(REG_UNUSED, 32'hffff_ffff); end
        default: begin reg_write(REG_FLOOR, 107374); reg_write(REG_MIN_THR, 19661);
                 reg_write(REG_MAX_THR, 52429); reg_write(REG_RATE, 6554);
                 reg_write(REG_INIT_THR, 39322); end
      endcase
      for (int b = 0; b < 30; b++) begin
        scale = (1 << $urandom_range(4, 15)) - 1;
        send_buffer($urandom_range(1, 6), scale, 1);
        if (ph == 2 && b == 5) hold_ready = 1;
      end
      drain();
    end
    // final stretch with no idling
    quiet_ready = 1;
    for (int b = 0; b < 100; b++) send_buffer($urandom_range(1, 4), 32767, 0);
    drain();
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
